// ----- sv/legt_pkg.sv -----
// Package for the line-end gap table: command and status codes, default sizes.
// Used by line_end_gap_table.
`default_nettype none
package legt_pkg;
  localparam int MaxLines = 1024;
  localparam int PosBits  = 24;
  localparam logic [7:0] Newline = 8'd10;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_BOUNDS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ----- sv/line_end_gap_table.sv -----
// Line-end gap table: sorted newline positions of a text kept as a gap buffer.
//
// Channels: input item (command, position, length, text_byte, row) on
// in_valid/in_ready; one result item per input on out_valid/out_ready.
// Each field is a port of its own.
// Insert moves the gap to the position (one memory read, then a write, per
// moved entry), then bumps the length and, for a newline, writes the new end.
// Delete moves the gap, then drops ends inside the span one per cycle.
// Find row is a binary search; each probe issues a read, then compares.
// Line bounds reads up to two entries.
// One item at a time: in_ready is high only while idle with no result
// waiting, so the next item can be accepted at the edge where the result
// is taken. A stalled receiver holds the result and keeps in_ready low.
// Reset clears gap pointers and length; the memory is not cleared.
`default_nettype none
module line_end_gap_table #(
  parameter int MAX_LINES = legt_pkg::MaxLines,
  parameter int POS_BITS  = legt_pkg::PosBits
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          command,
  input  wire  [POS_BITS-1:0] position,
  input  wire  [POS_BITS-1:0] length,
  input  wire  [7:0]          text_byte,
  input  wire  [10:0]         row,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          status,
  output logic [10:0]         found_row,
  output logic [POS_BITS-1:0] line_start,
  output logic [POS_BITS-1:0] line_end,
  output logic [10:0]         line_count,
  output logic [POS_BITS-1:0] text_size
);
  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_LINES);
  localparam logic [POS_BITS-1:0] PMAX = '1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MVDN  = 10'b0000000010,  // read below-gap top
    S_MVDNC = 10'b0000000100,
    S_MVUP  = 10'b0000001000,
    S_MVUPC = 10'b0000010000,
    S_FIN   = 10'b0000100000,  // apply insert / start drop / finish other items
    S_DROPC = 10'b0001000000,
    S_SRCH  = 10'b0010000000,
    S_SRCHC = 10'b0100000000,
    S_BND   = 10'b1000000000
  } state_t;

  state_t state;
  logic [POS_BITS-1:0] mem [MAX_LINES];
  logic [POS_BITS-1:0] rd;
  logic [CW-1:0] gap_low, gap_high;
  logic [POS_BITS-1:0] text_total;
  legt_pkg::cmd_t cmd;
  logic [POS_BITS-1:0] pos, len;
  logic [POS_BITS:0] stop;
  logic nl;
  logic [CW-1:0] lo, hi, mid;
  logic [10:0] qrow;
  logic bstep;
  logic [POS_BITS-1:0] bstart;

  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [POS_BITS-1:0] wdata;
  logic          re;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  logic [CW-1:0] count;
  assign count = CAP - (gap_high - gap_low);
  logic [POS_BITS-1:0] rd_abs;
  assign rd_abs = text_total - rd;
  logic [CW-1:0] mid_c;
  assign mid_c = lo + ((hi - lo) >> 1);
  // probe address is issued in the same cycle the probe index is chosen
  logic [CW-1:0] mid_phys;
  assign mid_phys = (mid_c < gap_low) ? mid_c : mid_c + (gap_high - gap_low);

  // bounds row address (row may need gap offset)
  logic [CW-1:0] brow, brow_phys;
  assign brow = bstep ? CW'(qrow) : CW'(qrow) - 1'b1;
  assign brow_phys = (brow < gap_low) ? brow : brow + (gap_high - gap_low);
  logic brow_rel;
  assign brow_rel = !(brow < gap_low);

  logic brel_q;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    case (state)
      S_MVDN: begin re = 1'b1; raddr = AW'(gap_low - 1'b1); end
      S_MVDNC: if (rd > pos) begin
        we = 1'b1; waddr = AW'(gap_high - 1'b1); wdata = text_total - rd;
      end
      S_MVUP: begin re = 1'b1; raddr = AW'(gap_high); end
      S_MVUPC: if (rd_abs <= pos) begin
        we = 1'b1; waddr = AW'(gap_low); wdata = rd_abs;
      end
      S_FIN: if (cmd == legt_pkg::CMD_INSERT && nl) begin
        we = 1'b1; waddr = AW'(gap_low); wdata = pos + 1'b1;
      end else if (cmd == legt_pkg::CMD_DELETE) begin
        re = 1'b1; raddr = AW'(gap_high);
      end
      S_DROPC: begin re = 1'b1; raddr = AW'(gap_high + 1'b1); end
      S_SRCH: begin re = 1'b1; raddr = AW'(mid_phys); end
      S_BND: begin re = 1'b1; raddr = AW'(brow_phys); end
      default: ;
    endcase
  end

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      gap_low <= '0; gap_high <= CAP; text_total <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_acc) begin
          pos <= position; len <= length;
          nl <= (text_byte == legt_pkg::Newline); qrow <= row;
          stop <= {1'b0, position} + {1'b0, length};
          found_row <= '0;
          line_start <= '0; line_end <= '0;
          lo <= '0; hi <= count;
          bstep <= (row == 11'd0);
          case (legt_pkg::cmd_t'(command))
            legt_pkg::CMD_INSERT: begin
              if (position > text_total) begin
                status <= legt_pkg::ST_RANGE; state <= S_FIN; cmd <= legt_pkg::CMD_FIND;
              end else if (text_total == PMAX ||
                           (text_byte == legt_pkg::Newline && gap_low >= gap_high)) begin
                status <= legt_pkg::ST_FULL; state <= S_FIN; cmd <= legt_pkg::CMD_FIND;
              end else begin
                status <= legt_pkg::ST_OK; state <= S_MVDN; cmd <= legt_pkg::CMD_INSERT;
              end
            end
            legt_pkg::CMD_DELETE: begin
              if ({1'b0, position} + {1'b0, length} > {1'b0, text_total}) begin
                status <= legt_pkg::ST_RANGE; state <= S_FIN; cmd <= legt_pkg::CMD_FIND;
              end else begin
                status <= legt_pkg::ST_OK; state <= S_MVDN; cmd <= legt_pkg::CMD_DELETE;
              end
            end
            legt_pkg::CMD_FIND: begin
              cmd <= legt_pkg::CMD_FIND;
              if (position > text_total) begin
                status <= legt_pkg::ST_RANGE; state <= S_FIN;
              end else begin
                status <= legt_pkg::ST_OK; state <= S_SRCH;
              end
            end
            default: begin
              cmd <= legt_pkg::CMD_BOUNDS;
              if (CW'(row) >= count || row > 11'(MAX_LINES)) begin
                status <= legt_pkg::ST_RANGE; state <= S_FIN;
              end else begin
                status <= legt_pkg::ST_OK; state <= S_BND;
              end
            end
          endcase
          mid <= '0;
        end
        S_MVDN: state <= (gap_low == '0) ? S_MVUP : S_MVDNC;
        S_MVDNC: if (rd > pos) begin
          gap_low <= gap_low - 1'b1; gap_high <= gap_high - 1'b1; state <= S_MVDN;
        end else state <= S_MVUP;
        S_MVUP: state <= (gap_high == CAP) ? S_FIN : S_MVUPC;
        S_MVUPC: if (rd_abs <= pos) begin
          gap_low <= gap_low + 1'b1; gap_high <= gap_high + 1'b1; state <= S_MVUP;
        end else state <= S_FIN;
        S_FIN: begin
          if (cmd == legt_pkg::CMD_INSERT) begin
            text_total <= text_total + 1'b1;
            if (nl) gap_low <= gap_low + 1'b1;
            line_count <= 11'(count + CW'(nl)); text_size <= text_total + 1'b1;
            out_valid <= 1'b1; state <= S_IDLE;
          end else if (cmd == legt_pkg::CMD_DELETE) begin
            if (gap_high == CAP) begin
              text_total <= text_total - len;
              line_count <= 11'(count); text_size <= text_total - len;
              out_valid <= 1'b1; state <= S_IDLE;
            end else state <= S_DROPC;
          end else begin
            line_count <= 11'(count); text_size <= text_total;
            out_valid <= 1'b1; state <= S_IDLE;
          end
        end
        S_DROPC: begin
          // rd holds entry at gap_high; next entry prefetched
          if ({1'b0, rd_abs} <= stop) begin
            gap_high <= gap_high + 1'b1;
            if (gap_high + 1'b1 == CAP) state <= S_FIN;
          end else begin
            text_total <= text_total - len;
            line_count <= 11'(count); text_size <= text_total - len;
            out_valid <= 1'b1; state <= S_IDLE;
          end
        end
        S_SRCH: begin
          if (hi > lo) begin
            mid <= mid_c; state <= S_SRCHC;
            brel_q <= !(mid_c < gap_low);
          end else begin
            found_row <= 11'(lo);
            line_count <= 11'(count); text_size <= text_total;
            out_valid <= 1'b1; state <= S_IDLE;
          end
        end
        S_SRCHC: begin
          if (pos < (brel_q ? rd_abs : rd)) hi <= mid;
          else lo <= mid + 1'b1;
          state <= S_SRCH;
        end
        default: begin // S_BND: one pass for row 0, else two; brel_q tracks read form
          brel_q <= brow_rel;
          if (mid == '0) mid <= CW'(1);
          else begin
            if (!bstep) begin
              bstart <= brel_q ? rd_abs : rd;
              bstep <= 1'b1; mid <= '0;
            end else begin
              line_start <= (qrow == 11'd0) ? '0 : bstart;
              line_end <= brel_q ? rd_abs : rd;
              line_count <= 11'(count); text_size <= text_total;
              out_valid <= 1'b1; state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  // During S_FIN for a delete with entries above the gap, the read issued
  // there feeds S_DROPC; each drop re-reads the next entry.

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid || $past(out_valid && !out_ready))
    else $error("result too early");
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_low <= gap_high && gap_high <= CAP) else $error("gap pointers crossed");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(text_size))
    else $error("result dropped");
endmodule
`default_nettype wire
